// File: sv/rgb_clear_normalize_gamma_defines.svh
// Assertion macros for the color normalization block.
// Included by the top level; the SYNTH build gets empty bodies.
`ifndef RGB_CLEAR_NORMALIZE_GAMMA_DEFINES_SVH
`define RGB_CLEAR_NORMALIZE_GAMMA_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset
`define RCNG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, sampled on clk, off during reset
`define RCNG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RCNG_ASSERT_IMP(label, ante, cons)
`define RCNG_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: sv/rcng_pkg.sv
// Shared types, constants and the gamma table for the color normalization block.
// No dependencies; every other file but the defines header refers to it by scoped names.
`default_nettype none
package rcng_pkg;

    localparam int COUNT_W             = 16;
    localparam int LEVEL_W             = 8;
    localparam int NUM_CHAN            = 3;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = LEVEL_W / DIV_STEPS_PER_STAGE;
    localparam int CFG_ADDR_W          = 3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [63:0]        CUBE_255           = 64'd16581375;
    localparam logic [LEVEL_W-1:0] GREEN_OFFSET_RESET = 8'd6;
    localparam logic               REG_GREEN_OFFSET   = 1'b0;

    typedef struct packed {
        logic [COUNT_W-1:0] red_count;
        logic [COUNT_W-1:0] green_count;
        logic [COUNT_W-1:0] blue_count;
        logic [COUNT_W-1:0] clear_count;
    } reading_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               dark_flag;
    } result_t;

    // One channel of the restoring divider: partial remainder, numerator
    // bits not yet shifted in, quotient so far, and the saturation mark
    typedef struct packed {
        logic [COUNT_W-1:0] rem;
        logic [LEVEL_W-1:0] low;
        logic [LEVEL_W-1:0] quo;
        logic               sat;
    } div_chan_t;

    typedef struct packed {
        div_chan_t [NUM_CHAN-1:0] chan;
        logic [COUNT_W-1:0]       clear;
        logic                     dark;
    } div_item_t;

    typedef logic [255:0][LEVEL_W-1:0] gamma_table_t;

    // Entry i is the largest k with k*k*255^3 <= i^5, found bit by bit
    function automatic gamma_table_t build_gamma();
        gamma_table_t       tbl;
        logic [63:0]        p5;
        logic [63:0]        t64;
        logic [LEVEL_W-1:0] k;
        logic [LEVEL_W-1:0] t;
        for (int i = 0; i < 256; i++)
        begin
            p5 = 64'(i) * 64'(i) * 64'(i) * 64'(i) * 64'(i);
            k  = '0;
            for (int b = LEVEL_W - 1; b >= 0; b--)
            begin
                t   = k | (LEVEL_W'(1) << b);
                t64 = 64'(t);
                if (t64 * t64 * CUBE_255 <= p5)
                    k = t;
            end
            tbl[i] = k;
        end
        return tbl;
    endfunction

    localparam gamma_table_t GAMMA_ROM = build_gamma();

endpackage
`default_nettype wire

// File: sv/rcng_prep.sv
// Entry stage: scales each color by 255 and seeds the divider.
// Depends on rcng_pkg.
`default_nettype none
module rcng_prep (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire rcng_pkg::reading_t  up_item,
    output logic                     down_valid,
    input  wire logic                down_ready,
    output rcng_pkg::div_item_t      down_item
);

    logic                           valid_reg;
    rcng_pkg::div_item_t            item_reg;
    rcng_pkg::div_item_t            item_next;
    logic [rcng_pkg::COUNT_W-1:0]   colour [rcng_pkg::NUM_CHAN];
    logic [rcng_pkg::COUNT_W+7:0]   scaled [rcng_pkg::NUM_CHAN];

    assign colour[rcng_pkg::CH_RED]   = up_item.red_count;
    assign colour[rcng_pkg::CH_GREEN] = up_item.green_count;
    assign colour[rcng_pkg::CH_BLUE]  = up_item.blue_count;

    // Form colour*255 and split it into the first partial remainder and
    // the low bits still to shift in; a colour at or above clear saturates
    always_comb
    begin
        item_next.clear = up_item.clear_count;
        item_next.dark  = (up_item.clear_count == '0);
        for (int c = 0; c < rcng_pkg::NUM_CHAN; c++)
        begin
            scaled[c] = {colour[c], 8'b0} - {8'b0, colour[c]};
            item_next.chan[c].rem = scaled[c][rcng_pkg::COUNT_W+7:8];
            item_next.chan[c].low = scaled[c][7:0];
            item_next.chan[c].quo = '0;
            item_next.chan[c].sat = (colour[c] >= up_item.clear_count);
        end
    end

    assign up_ready = !valid_reg || down_ready;

    // Hold while the next stage stalls, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

    assign down_valid = valid_reg;
    assign down_item  = item_reg;

endmodule
`default_nettype wire

// File: sv/rcng_div_stage.sv
// One stage of the pipelined restoring divider: two quotient bits per
// channel per stage. Depends on rcng_pkg.
`default_nettype none
module rcng_div_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire rcng_pkg::div_item_t  up_item,
    output logic                      down_valid,
    input  wire logic                 down_ready,
    output rcng_pkg::div_item_t       down_item
);

    logic                          valid_reg;
    rcng_pkg::div_item_t           item_reg;
    rcng_pkg::div_item_t           item_next;
    logic [rcng_pkg::COUNT_W-1:0]  rem;
    logic [rcng_pkg::COUNT_W:0]    trial;
    logic [rcng_pkg::LEVEL_W-1:0]  low;
    logic [rcng_pkg::LEVEL_W-1:0]  quo;

    // For each step, shift in the next numerator bit and subtract the divisor if it fits
    always_comb
    begin
        item_next = up_item;
        rem       = '0;
        trial     = '0;
        low       = '0;
        quo       = '0;
        for (int c = 0; c < rcng_pkg::NUM_CHAN; c++)
        begin
            rem = up_item.chan[c].rem;
            low = up_item.chan[c].low;
            quo = up_item.chan[c].quo;
            for (int s = 0; s < rcng_pkg::DIV_STEPS_PER_STAGE; s++)
            begin
                trial = {rem, low[rcng_pkg::LEVEL_W-1]};
                low   = {low[rcng_pkg::LEVEL_W-2:0], 1'b0};
                if (trial >= {1'b0, up_item.clear})
                begin
                    trial = trial - {1'b0, up_item.clear};
                    quo   = {quo[rcng_pkg::LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    quo   = {quo[rcng_pkg::LEVEL_W-2:0], 1'b0};
                end
                rem = trial[rcng_pkg::COUNT_W-1:0];
            end
            item_next.chan[c].rem = rem;
            item_next.chan[c].low = low;
            item_next.chan[c].quo = quo;
        end
    end

    assign up_ready = !valid_reg || down_ready;

    // Hold while the next stage stalls, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

    assign down_valid = valid_reg;
    assign down_item  = item_reg;

endmodule
`default_nettype wire

// File: sv/rcng_level.sv
// Output stage: saturates the ratio, reads the gamma table, applies the
// green offset and holds the result item. Depends on rcng_pkg.
`default_nettype none
module rcng_level (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire rcng_pkg::div_item_t           up_item,
    input  wire logic [rcng_pkg::LEVEL_W-1:0]  green_offset,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output rcng_pkg::result_t                  result
);

    logic                          valid_reg;
    rcng_pkg::result_t             result_reg;
    rcng_pkg::result_t             result_next;
    logic [rcng_pkg::LEVEL_W-1:0]  ratio [rcng_pkg::NUM_CHAN];
    logic [rcng_pkg::LEVEL_W-1:0]  level [rcng_pkg::NUM_CHAN];

    // Dark forces ratio 0, saturation forces full scale
    always_comb
    begin
        for (int c = 0; c < rcng_pkg::NUM_CHAN; c++)
        begin
            priority if (up_item.dark)
                ratio[c] = '0;
            else if (up_item.chan[c].sat)
                ratio[c] = '1;
            else
                ratio[c] = up_item.chan[c].quo;
            level[c] = rcng_pkg::GAMMA_ROM[ratio[c]];
        end
    end

    // Subtract the green offset, clamp at zero
    always_comb
    begin
        result_next.red_level  = level[rcng_pkg::CH_RED];
        result_next.blue_level = level[rcng_pkg::CH_BLUE];
        result_next.dark_flag  = up_item.dark;
        if (level[rcng_pkg::CH_GREEN] > green_offset)
            result_next.green_level = level[rcng_pkg::CH_GREEN] - green_offset;
        else
            result_next.green_level = '0;
    end

    assign up_ready = !valid_reg || result_ready;

    // Hold the result item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// File: sv/rgb_clear_normalize_gamma.sv
// Pipeline: an accepted reading passes the entry stage, four divider stages at two
// quotient bits each, and the gamma and offset stage before its result item appears.
// Throughput: one item per cycle while results are taken; each stage holds its item
// under backpressure and fills bubbles, so a stall loses and repeats nothing.
// Reset (rst_n, async, active low): all stages empty, green_offset = 6.
// Depends on rcng_pkg, rcng_prep, rcng_div_stage, rcng_level and the defines header.
`default_nettype none
`include "rgb_clear_normalize_gamma_defines.svh"
module rgb_clear_normalize_gamma (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             reading_valid,
    output logic                                  reading_ready,
    input  wire rcng_pkg::reading_t               reading,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output rcng_pkg::result_t                     result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rcng_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [rcng_pkg::LEVEL_W-1:0]  green_offset_reg;
    logic                          cfg_write;
    logic                          stage_valid [rcng_pkg::DIV_STAGES+1];
    logic                          stage_ready [rcng_pkg::DIV_STAGES+1];
    rcng_pkg::div_item_t           stage_item  [rcng_pkg::DIV_STAGES+1];

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == rcng_pkg::REG_GREEN_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            green_offset_reg <= rcng_pkg::GREEN_OFFSET_RESET;
        else if (cfg_write)
            green_offset_reg <= pwdata[rcng_pkg::LEVEL_W-1:0];
    end

    always_comb
    begin
        if (paddr[2] == rcng_pkg::REG_GREEN_OFFSET)
            prdata = 32'(green_offset_reg);
        else
            prdata = '0;
    end

    // Entry stage
    rcng_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (reading_valid),
        .up_ready   (reading_ready),
        .up_item    (reading),
        .down_valid (stage_valid[0]),
        .down_ready (stage_ready[0]),
        .down_item  (stage_item[0])
    );

    // Divider stages
    for (genvar g = 0; g < rcng_pkg::DIV_STAGES; g++)
    begin : g_div
        rcng_div_stage u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[g]),
            .up_ready   (stage_ready[g]),
            .up_item    (stage_item[g]),
            .down_valid (stage_valid[g+1]),
            .down_ready (stage_ready[g+1]),
            .down_item  (stage_item[g+1])
        );
    end

    // Gamma lookup, offset and output register
    rcng_level u_level (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (stage_valid[rcng_pkg::DIV_STAGES]),
        .up_ready     (stage_ready[rcng_pkg::DIV_STAGES]),
        .up_item      (stage_item[rcng_pkg::DIV_STAGES]),
        .green_offset (green_offset_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A dark item carries all levels at zero
    `RCNG_ASSERT_IMP(a_dark_levels_zero, result_valid && result.dark_flag, (result.red_level == '0) && (result.green_level == '0) && (result.blue_level == '0))
    // Backpressure at the input only arises from a stalled full pipeline
    `RCNG_ASSERT_IMP(a_stall_from_output, !reading_ready, result_valid && !result_ready)
    // A register write lands in the offset register
    `RCNG_ASSERT_NXT(a_offset_written, cfg_write, green_offset_reg == $past(pwdata[7:0]))

endmodule
`default_nettype wire

// File: dv/rgb_clear_normalize_gamma_test.sv
// Self-checking testbench for the color normalization block: directed table, then random readings.
// Depends on rcng_pkg for the reading/result types and widths, and on the top level under test.
`timescale 1ns / 100ps
module rgb_clear_normalize_gamma_test;

    localparam int LATENCY     = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 19;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 80;
    localparam int SPARE_REG   = 1;

    localparam logic [rcng_pkg::CFG_ADDR_W-1:0] GREEN_OFFSET_ADDR =
        rcng_pkg::CFG_ADDR_W'(rcng_pkg::REG_GREEN_OFFSET) << 2;
    localparam logic [rcng_pkg::CFG_ADDR_W-1:0] SPARE_ADDR =
        rcng_pkg::CFG_ADDR_W'(SPARE_REG * 4);

    // One row of the directed table: reading, whether the result is typed in, and that result
    typedef struct packed {
        rcng_pkg::reading_t rd;
        logic               fixed;
        rcng_pkg::result_t  want;
    } stim_row_t;

    localparam int NUM_ROWS = 16;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // dark reading, all zero
        {16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
        // dark reading with full colors
        {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
        // dark reading with alternating bits
        {16'h5555, 16'hAAAA, 16'h5555, 16'h0000, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
        // colors equal to clear at full scale
        {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'd255, 8'd249, 8'd255, 1'b0},
        // colors equal to clear at mid scale
        {16'h1234, 16'h1234, 16'h1234, 16'h1234, 1'b1, 8'd255, 8'd249, 8'd255, 1'b0},
        // colors far above clear, and equal to a clear of one, saturate
        {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b1, 8'd255, 8'd249, 8'd255, 1'b0},
        {16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1, 8'd255, 8'd249, 8'd255, 1'b0},
        // zero colors, green offset clamps at zero
        {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
        // mixed ratios, some with a small green just above or below the offset
        {16'hFFFF, 16'h4000, 16'h8000, 16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'h0101, 16'h2000, 16'hFFFE, 16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFE, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'h0001, 16'h8000, 16'h00FF, 16'h8000, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'h00FE, 16'h0080, 16'h0001, 16'h00FF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        {16'h8001, 16'h3FFF, 16'hC000, 16'h8000, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0}
    };

    logic                              clk;
    logic                              rst_n;
    logic                              reading_valid;
    logic                              reading_ready;
    rcng_pkg::reading_t                reading;
    logic                              result_valid;
    logic                              result_ready;
    rcng_pkg::result_t                 result;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [rcng_pkg::CFG_ADDR_W-1:0]   paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    logic [rcng_pkg::LEVEL_W-1:0] gamma_curve [256];
    logic [rcng_pkg::LEVEL_W-1:0] offset_now;
    rcng_pkg::result_t            pending_levels [$];
    logic                         steady;
    int                           error_count;
    int                           readings_sent;
    int                           levels_checked;
    int                           dark_count;
    int                           saturated_count;
    int                           offsets_tried;

    rgb_clear_normalize_gamma uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .reading_valid (reading_valid),
        .reading_ready (reading_ready),
        .reading       (reading),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Clamped ratio colour*255/clear, zero when the clear count is zero
    function automatic logic [rcng_pkg::LEVEL_W-1:0] scaled_ratio(
        logic [rcng_pkg::COUNT_W-1:0] colour,
        logic [rcng_pkg::COUNT_W-1:0] clear);
        logic [31:0] q;
        if (clear == '0)
            return '0;
        q = (32'(colour) * 32'd255) / 32'(clear);
        return (q > 32'd255) ? 8'hFF : q[rcng_pkg::LEVEL_W-1:0];
    endfunction

    // Expected levels for one reading under the current green offset
    function automatic rcng_pkg::result_t predict_levels(rcng_pkg::reading_t rd);
        rcng_pkg::result_t            res;
        logic [rcng_pkg::LEVEL_W-1:0] g;
        res.red_level   = gamma_curve[scaled_ratio(rd.red_count, rd.clear_count)];
        g               = gamma_curve[scaled_ratio(rd.green_count, rd.clear_count)];
        res.green_level = (g > offset_now) ? g - offset_now : '0;
        res.blue_level  = gamma_curve[scaled_ratio(rd.blue_count, rd.clear_count)];
        res.dark_flag   = (rd.clear_count == '0);
        return res;
    endfunction

    // Color count spread around the clear count, so ratios cover 0..255 and saturation
    function automatic logic [rcng_pkg::COUNT_W-1:0] colour_near(
        logic [rcng_pkg::COUNT_W-1:0] clear);
        logic [31:0] scaled;
        scaled = ($urandom_range(300) * 32'(clear)) / 255;
        return (scaled > 32'hFFFF) ? 16'hFFFF : scaled[rcng_pkg::COUNT_W-1:0];
    endfunction

    function automatic rcng_pkg::reading_t random_reading();
        rcng_pkg::reading_t rd;
        int unsigned        mode;
        mode = $urandom_range(99);
        rd   = {$urandom(), $urandom()};
        if (mode < 6)
            rd.clear_count = '0;
        else if (mode >= 30)
        begin
            // one time in four a small divisor keeps the ratio steps coarse
            if ($urandom_range(3) == 0)
                rd.clear_count = rcng_pkg::COUNT_W'($urandom_range(255, 1));
            rd.red_count   = colour_near(rd.clear_count);
            rd.green_count = colour_near(rd.clear_count);
            rd.blue_count  = colour_near(rd.clear_count);
        end
        return rd;
    endfunction

    // Offer one reading, hold it until accepted, then queue its expected levels
    task automatic offer_reading(input rcng_pkg::reading_t rd, input logic fixed,
                                 input rcng_pkg::result_t want);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            reading_valid <= 1'b0;
            @(negedge clk);
        end
        reading_valid <= 1'b1;
        reading       <= rd;
        do
            @(posedge clk);
        while (!reading_ready);
        pending_levels.push_back(fixed ? want : predict_levels(rd));
        readings_sent++;
        if (rd.clear_count == '0)
            dark_count++;
        else if (rd.red_count > rd.clear_count || rd.green_count > rd.clear_count
                 || rd.blue_count > rd.clear_count)
            saturated_count++;
    endtask

    // Drop valid and wait for every queued result plus the pipeline depth
    task automatic drain_results();
        @(negedge clk);
        reading_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write,
                              input logic [rcng_pkg::CFG_ADDR_W-1:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (is_write && addr == GREEN_OFFSET_ADDR)
            offset_now = data[rcng_pkg::LEVEL_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_offset_readback();
        logic [31:0] rdata;
        apb_access(1'b0, GREEN_OFFSET_ADDR, '0, rdata);
        if (rdata[rcng_pkg::LEVEL_W-1:0] !== offset_now)
        begin
            $display("%0t: green_offset readback expected %0d, got %0d",
                     $time, offset_now, rdata[rcng_pkg::LEVEL_W-1:0]);
            error_count++;
        end
    endtask

    // Settle, write one register, read back the green offset, then stream random readings
    task automatic run_phase(input logic [rcng_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data,
                             input logic no_idle, input int count, input logic pause_mid);
        logic [31:0] unused;
        drain_results();
        apb_access(1'b1, addr, data, unused);
        check_offset_readback();
        offsets_tried++;
        steady = no_idle;
        for (int n = 0; n < count; n++)
        begin
            if (pause_mid && n == count / 2)
                drain_results();
            offer_reading(random_reading(), 1'b0, '0);
        end
        steady = 1'b0;
    endtask

    // Receiver: random ready with one long hold, checks each result item
    initial
    begin
        int hold_left;
        bit held;
        rcng_pkg::result_t want;
        hold_left    = 0;
        held         = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && levels_checked >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                levels_checked++;
                if (pending_levels.size() == 0)
                begin
                    $display("%0t: result item with none expected, got %p", $time, result);
                    error_count++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (result.red_level !== want.red_level)
                    begin
                        $display("%0t: red_level expected %0d, got %0d",
                                 $time, want.red_level, result.red_level);
                        error_count++;
                    end
                    if (result.green_level !== want.green_level)
                    begin
                        $display("%0t: green_level expected %0d, got %0d",
                                 $time, want.green_level, result.green_level);
                        error_count++;
                    end
                    if (result.blue_level !== want.blue_level)
                    begin
                        $display("%0t: blue_level expected %0d, got %0d",
                                 $time, want.blue_level, result.blue_level);
                        error_count++;
                    end
                    if (result.dark_flag !== want.dark_flag)
                    begin
                        $display("%0t: dark_flag expected %0b, got %0b",
                                 $time, want.dark_flag, result.dark_flag);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((reading_valid && reading_ready) || (result_valid && result_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_levels.size());
                $display("rgb_clear_normalize_gamma_test: errors");
                $finish;
            end
        end
    end

    // Sender: reset, directed table, then configuration phases with random readings
    initial
    begin
        logic [63:0] p5;
        logic [63:0] k;
        rst_n           = 1'b0;
        reading_valid   = 1'b0;
        reading         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        steady          = 1'b0;
        error_count     = 0;
        readings_sent   = 0;
        levels_checked  = 0;
        dark_count      = 0;
        saturated_count = 0;
        offsets_tried   = 1;
        offset_now      = rcng_pkg::GREEN_OFFSET_RESET;

        // gamma entry i: largest k with k*k*255^3 <= i^5
        for (int i = 0; i < 256; i++)
        begin
            p5 = 64'(i) * 64'(i) * 64'(i) * 64'(i) * 64'(i);
            k  = 0;
            while (k < 255 && (k + 1) * (k + 1) * 64'd16581375 <= p5)
                k++;
            gamma_curve[i] = k[rcng_pkg::LEVEL_W-1:0];
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_offset_readback();
        for (int r = 0; r < NUM_ROWS; r++)
            offer_reading(DIRECTED_ROWS[r].rd, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);

        run_phase(GREEN_OFFSET_ADDR, 32'h0000_0000, 1'b0, 120, 1'b0);
        // upper data bits set: only the low byte lands
        run_phase(GREEN_OFFSET_ADDR, 32'hFFFF_FFFF, 1'b0, 100, 1'b0);
        // write to an unused register must leave the offset alone
        run_phase(SPARE_ADDR, 32'h0000_0042, 1'b0, 100, 1'b1);
        run_phase(GREEN_OFFSET_ADDR, $urandom(), 1'b1, 150, 1'b0);
        run_phase(GREEN_OFFSET_ADDR, $urandom_range(40), 1'b0, 130, 1'b0);
        run_phase(GREEN_OFFSET_ADDR, 32'(rcng_pkg::GREEN_OFFSET_RESET), 1'b0, 150, 1'b0);

        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        $display("Sent %0d readings (%0d dark, %0d with a color above clear), checked %0d results",
                 readings_sent, dark_count, saturated_count, levels_checked);
        $display("Green offset settings exercised: %0d, including 0, 255 and an unused register",
                 offsets_tried);
        if (error_count == 0)
            $display("rgb_clear_normalize_gamma_test: clean");
        else
            $display("rgb_clear_normalize_gamma_test: errors");
        $finish;
    end

endmodule
